[design/kpl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpl_pkg
// Shared types, codes and reset values of the keypad lock controller.
// ----------------------------------------------------------------------------
package kpl_pkg;

	// default sizing
	localparam int DEF_MAX_PIN_KEYS = 8;
	localparam int DEF_TIMER_BITS   = 17;

	// width used to compare lengths against the buffer depth
	localparam int LEN_CMP_W = 5;

	// event opcodes
	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_KEY  = 2'd1,
		OP_VIB  = 2'd2,
		OP_CMD  = 2'd3
	} op_t;

	// lock modes
	typedef enum logic [2:0] {
		MODE_LOCKED   = 3'd0,
		MODE_UNLOCKED = 3'd1,
		MODE_AWAIT    = 3'd2,
		MODE_ADMIN    = 3'd3,
		MODE_MESSAGE  = 3'd4,
		MODE_ALARM    = 3'd5,
		MODE_START    = 3'd6
	} mode_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_MASTER_CODE   = 3'd0,
		REG_MASTER_LENGTH = 3'd1,
		REG_ADMIN_CODE    = 3'd2,
		REG_ADMIN_LENGTH  = 3'd3,
		REG_AUTOLOCK      = 3'd4,
		REG_ENTRY_TIMEOUT = 3'd5,
		REG_ADMIN_HOLD    = 3'd6,
		REG_MESSAGE       = 3'd7
	} reg_idx_t;

	// serial commands
	localparam logic [2:0] CMD_UNLOCK    = 3'd1;
	localparam logic [2:0] CMD_LOCK      = 3'd2;
	localparam logic [2:0] CMD_DISARM    = 3'd3;
	localparam logic [2:0] CMD_WIFI_UP   = 3'd4;
	localparam logic [2:0] CMD_WIFI_DOWN = 3'd5;

	// special keys
	localparam logic [3:0] KEY_STAR = 4'd14;
	localparam logic [3:0] KEY_HASH = 4'd15;

	// link status
	localparam logic [1:0] LINK_UNKNOWN = 2'd0;
	localparam logic [1:0] LINK_UP      = 2'd1;
	localparam logic [1:0] LINK_DOWN    = 2'd2;

	// notify pulses
	localparam logic [2:0] NOTIFY_NONE     = 3'd0;
	localparam logic [2:0] NOTIFY_LOCKED   = 3'd1;
	localparam logic [2:0] NOTIFY_UNLOCKED = 3'd2;
	localparam logic [2:0] NOTIFY_ADMIN    = 3'd3;
	localparam logic [2:0] NOTIFY_TAMPER   = 3'd4;

	// buzzer patterns
	localparam logic [2:0] BUZZ_NONE   = 3'd0;
	localparam logic [2:0] BUZZ_ALARM  = 3'd1;
	localparam logic [2:0] BUZZ_ADMIN  = 3'd2;
	localparam logic [2:0] BUZZ_ACCEPT = 3'd3;
	localparam logic [2:0] BUZZ_REJECT = 3'd4;

	// display screens
	localparam logic [3:0] DISP_NONE     = 4'd0;
	localparam logic [3:0] DISP_LOCKED   = 4'd1;
	localparam logic [3:0] DISP_UNLOCKED = 4'd2;
	localparam logic [3:0] DISP_ENTER    = 4'd3;
	localparam logic [3:0] DISP_ECHO     = 4'd4;
	localparam logic [3:0] DISP_ADMIN    = 4'd5;
	localparam logic [3:0] DISP_TIMEOUT  = 4'd6;
	localparam logic [3:0] DISP_WRONG    = 4'd7;
	localparam logic [3:0] DISP_TAMPER   = 4'd8;

	// configuration reset values
	localparam logic [31:0] RST_MASTER_CODE   = 32'h0000_4321;
	localparam logic [3:0]  RST_MASTER_LENGTH = 4'd4;
	localparam logic [31:0] RST_ADMIN_CODE    = 32'h0000_9999;
	localparam logic [3:0]  RST_ADMIN_LENGTH  = 4'd4;
	localparam logic [15:0] RST_AUTOLOCK      = 16'd10000;
	localparam logic [15:0] RST_ENTRY_TIMEOUT = 16'd10000;
	localparam logic [15:0] RST_ADMIN_HOLD    = 16'd5000;
	localparam logic [15:0] RST_MESSAGE       = 16'd2000;

	// configuration register file contents
	typedef struct packed {
		logic [31:0] master_code;
		logic [3:0]  master_length;
		logic [31:0] admin_code;
		logic [3:0]  admin_length;
		logic [15:0] autolock_ms;
		logic [15:0] entry_timeout_ms;
		logic [15:0] admin_hold_ms;
		logic [15:0] message_ms;
	} cfg_t;

	// pin buffer control from the step logic
	typedef struct packed {
		logic       clear;
		logic       push;
		logic [3:0] key;
	} buf_ctl_t;

	// pin buffer compare results
	typedef struct packed {
		logic hit_master;
		logic hit_admin;
	} buf_hit_t;

endpackage

[design/kpl_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpl_cfg_regs
// Configuration register file, one register written per handshake.
// ----------------------------------------------------------------------------
module kpl_cfg_regs
	import kpl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  reg_idx_t    wr_index,
	input  logic [31:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.master_code      <= RST_MASTER_CODE;
			cfg_q.master_length    <= RST_MASTER_LENGTH;
			cfg_q.admin_code       <= RST_ADMIN_CODE;
			cfg_q.admin_length     <= RST_ADMIN_LENGTH;
			cfg_q.autolock_ms      <= RST_AUTOLOCK;
			cfg_q.entry_timeout_ms <= RST_ENTRY_TIMEOUT;
			cfg_q.admin_hold_ms    <= RST_ADMIN_HOLD;
			cfg_q.message_ms       <= RST_MESSAGE;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MASTER_CODE:   cfg_q.master_code      <= wr_data;
				REG_MASTER_LENGTH: cfg_q.master_length    <= wr_data[3:0];
				REG_ADMIN_CODE:    cfg_q.admin_code       <= wr_data;
				REG_ADMIN_LENGTH:  cfg_q.admin_length     <= wr_data[3:0];
				REG_AUTOLOCK:      cfg_q.autolock_ms      <= wr_data[15:0];
				REG_ENTRY_TIMEOUT: cfg_q.entry_timeout_ms <= wr_data[15:0];
				REG_ADMIN_HOLD:    cfg_q.admin_hold_ms    <= wr_data[15:0];
				REG_MESSAGE:       cfg_q.message_ms       <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/kpl_pin_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpl_pin_buffer
// PIN entry buffer with fill count, overflow flag and parallel code compare.
// ----------------------------------------------------------------------------
module kpl_pin_buffer
	import kpl_pkg::*;
#(
	parameter int MAX_PIN_KEYS = DEF_MAX_PIN_KEYS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  buf_ctl_t   ctl,
	input  cfg_t       cfg,
	output buf_hit_t   hit,
	output logic [3:0] entry_count
);

	localparam int LEN_W = $clog2(MAX_PIN_KEYS + 1);
	localparam int IDX_W = (MAX_PIN_KEYS > 1) ? $clog2(MAX_PIN_KEYS) : 1;

	logic [3:0]       keys_q [MAX_PIN_KEYS];
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic             full;

	assign full = (len_q >= LEN_W'(MAX_PIN_KEYS));

	// key storage, no reset needed
	always_ff @(posedge clk) begin
		if (en && ctl.push && !ctl.clear && !full) begin
			keys_q[len_q[IDX_W-1:0]] <= ctl.key;
		end
	end

	// fill count and overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (en) begin
			if (ctl.clear) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end else if (ctl.push) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					len_q <= len_q + LEN_W'(1);
				end
			end
		end
	end

	// per-key compare against both codes
	logic [MAX_PIN_KEYS-1:0] bad_master;
	logic [MAX_PIN_KEYS-1:0] bad_admin;

	for (genvar i = 0; i < MAX_PIN_KEYS; i++) begin : g_key
		logic [3:0] nib_master;
		logic [3:0] nib_admin;
		logic       used;
		if (i < 8) begin : g_nib
			assign nib_master = cfg.master_code[4*i +: 4];
			assign nib_admin  = cfg.admin_code[4*i +: 4];
		end else begin : g_zero
			assign nib_master = 4'd0;
			assign nib_admin  = 4'd0;
		end
		assign used          = (LEN_W'(i) < len_q);
		assign bad_master[i] = used && (keys_q[i] != nib_master);
		assign bad_admin[i]  = used && (keys_q[i] != nib_admin);
	end

	// whole-code match
	assign hit.hit_master = !ovf_q && !(|bad_master)
		&& (LEN_CMP_W'(cfg.master_length) == LEN_CMP_W'(len_q))
		&& (LEN_CMP_W'(cfg.master_length) <= LEN_CMP_W'(MAX_PIN_KEYS));
	assign hit.hit_admin = !ovf_q && !(|bad_admin)
		&& (LEN_CMP_W'(cfg.admin_length) == LEN_CMP_W'(len_q))
		&& (LEN_CMP_W'(cfg.admin_length) <= LEN_CMP_W'(MAX_PIN_KEYS));

	assign entry_count = 4'(len_q);

endmodule

[design/kpl_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpl_step
// Per-event lock state machine: next state and result word for one event.
// ----------------------------------------------------------------------------
module kpl_step
	import kpl_pkg::*;
#(
	parameter int TIMER_BITS = DEF_TIMER_BITS
) (
	input  op_t                   opcode,
	input  logic [3:0]            key_code,
	input  logic [2:0]            command_code,
	input  logic                  door_closed,
	input  cfg_t                  cfg,
	input  buf_hit_t              hit,
	input  mode_t                 mode_q,
	input  logic [TIMER_BITS-1:0] elapsed_q,
	input  logic                  tamper_q,
	input  logic [1:0]            link_q,
	output mode_t                 mode_nxt,
	output logic [TIMER_BITS-1:0] elapsed_nxt,
	output logic                  tamper_nxt,
	output logic [1:0]            link_nxt,
	output buf_ctl_t              buf_ctl,
	output logic [2:0]            notify_code,
	output logic [2:0]            buzzer_code,
	output logic [3:0]            display_code
);

	logic                  is_key;
	logic                  is_cmd;
	logic [TIMER_BITS-1:0] elapsed_a;
	logic                  tamper_a;
	logic [1:0]            link_wifi;
	logic                  over_autolock;
	logic                  over_entry;
	logic                  over_admin;
	logic                  over_message;

	// event applied before the mode handler
	assign is_key    = (opcode == OP_KEY);
	assign is_cmd    = (opcode == OP_CMD);
	assign elapsed_a = ((opcode == OP_TICK) && !(&elapsed_q)) ?
		elapsed_q + TIMER_BITS'(1) : elapsed_q;
	assign tamper_a  = tamper_q || (opcode == OP_VIB);
	assign link_wifi = (command_code == CMD_WIFI_UP)   ? LINK_UP :
	                   (command_code == CMD_WIFI_DOWN) ? LINK_DOWN : link_q;

	// timer limits
	assign over_autolock = elapsed_a > TIMER_BITS'(cfg.autolock_ms);
	assign over_entry    = elapsed_a > TIMER_BITS'(cfg.entry_timeout_ms);
	assign over_admin    = elapsed_a > TIMER_BITS'(cfg.admin_hold_ms);
	assign over_message  = elapsed_a > TIMER_BITS'(cfg.message_ms);

	// next state
	always_comb begin
		mode_nxt    = mode_q;
		elapsed_nxt = elapsed_a;
		tamper_nxt  = tamper_a;
		link_nxt    = link_q;
		buf_ctl     = '0;
		buf_ctl.key = key_code;
		unique case (mode_q)
			MODE_LOCKED: begin
				if (tamper_a) begin
					mode_nxt   = MODE_ALARM;
					tamper_nxt = 1'b0;
				end else if (is_cmd && command_code == CMD_UNLOCK) begin
					mode_nxt      = MODE_UNLOCKED;
					buf_ctl.clear = 1'b1;
					elapsed_nxt   = '0;
				end else begin
					if (is_cmd) begin
						link_nxt = link_wifi;
					end
					if (is_key) begin
						buf_ctl.push = 1'b1;
						mode_nxt     = MODE_AWAIT;
						elapsed_nxt  = '0;
					end
				end
			end
			MODE_UNLOCKED: begin
				if (is_cmd && command_code == CMD_LOCK) begin
					mode_nxt      = MODE_LOCKED;
					buf_ctl.clear = 1'b1;
				end else begin
					if (is_cmd) begin
						link_nxt = link_wifi;
					end
					if (over_autolock && door_closed) begin
						mode_nxt      = MODE_LOCKED;
						buf_ctl.clear = 1'b1;
					end
				end
			end
			MODE_AWAIT: begin
				if (is_key) begin
					elapsed_nxt = '0;
					if (key_code == KEY_HASH) begin
						if (hit.hit_master) begin
							mode_nxt      = MODE_UNLOCKED;
							buf_ctl.clear = 1'b1;
						end else if (hit.hit_admin) begin
							mode_nxt = MODE_ADMIN;
						end else begin
							mode_nxt = MODE_MESSAGE;
						end
					end else if (key_code == KEY_STAR) begin
						mode_nxt      = MODE_LOCKED;
						buf_ctl.clear = 1'b1;
					end else begin
						buf_ctl.push = 1'b1;
					end
				end else if (over_entry) begin
					mode_nxt    = MODE_MESSAGE;
					elapsed_nxt = '0;
				end
			end
			MODE_ADMIN: begin
				if (over_admin) begin
					mode_nxt      = MODE_LOCKED;
					buf_ctl.clear = 1'b1;
				end
			end
			MODE_MESSAGE: begin
				if (over_message) begin
					mode_nxt      = MODE_LOCKED;
					buf_ctl.clear = 1'b1;
				end
			end
			MODE_ALARM: begin
				if (is_cmd && command_code == CMD_DISARM) begin
					mode_nxt      = MODE_LOCKED;
					buf_ctl.clear = 1'b1;
				end
			end
			default: begin
				buf_ctl.clear = 1'b1;
				if (door_closed) begin
					mode_nxt = MODE_LOCKED;
				end else begin
					mode_nxt    = MODE_UNLOCKED;
					elapsed_nxt = '0;
				end
			end
		endcase
	end

	// result word
	always_comb begin
		notify_code  = NOTIFY_NONE;
		buzzer_code  = BUZZ_NONE;
		display_code = DISP_NONE;
		unique case (mode_q)
			MODE_LOCKED: begin
				if (tamper_a) begin
					display_code = DISP_TAMPER;
					notify_code  = NOTIFY_TAMPER;
				end else if (is_cmd && command_code == CMD_UNLOCK) begin
					display_code = DISP_UNLOCKED;
					notify_code  = NOTIFY_UNLOCKED;
				end else if (is_key) begin
					display_code = DISP_ENTER;
				end
			end
			MODE_UNLOCKED: begin
				if ((is_cmd && command_code == CMD_LOCK) || (over_autolock && door_closed)) begin
					display_code = DISP_LOCKED;
					notify_code  = NOTIFY_LOCKED;
				end
			end
			MODE_AWAIT: begin
				if (is_key) begin
					if (key_code == KEY_HASH) begin
						if (hit.hit_master) begin
							buzzer_code  = BUZZ_ACCEPT;
							display_code = DISP_UNLOCKED;
							notify_code  = NOTIFY_UNLOCKED;
						end else if (hit.hit_admin) begin
							buzzer_code  = BUZZ_ADMIN;
							display_code = DISP_ADMIN;
							notify_code  = NOTIFY_ADMIN;
						end else begin
							buzzer_code  = BUZZ_REJECT;
							display_code = DISP_WRONG;
						end
					end else if (key_code == KEY_STAR) begin
						display_code = DISP_LOCKED;
						notify_code  = NOTIFY_LOCKED;
					end else begin
						display_code = DISP_ECHO;
					end
				end else if (over_entry) begin
					display_code = DISP_TIMEOUT;
				end
			end
			MODE_ADMIN: begin
				if (over_admin) begin
					display_code = DISP_LOCKED;
					notify_code  = NOTIFY_LOCKED;
				end
			end
			MODE_MESSAGE: begin
				if (over_message) begin
					display_code = DISP_LOCKED;
					notify_code  = NOTIFY_LOCKED;
				end
			end
			MODE_ALARM: begin
				buzzer_code = BUZZ_ALARM;
				if (is_cmd && command_code == CMD_DISARM) begin
					display_code = DISP_LOCKED;
					notify_code  = NOTIFY_LOCKED;
				end
			end
			default: begin
				if (door_closed) begin
					display_code = DISP_LOCKED;
					notify_code  = NOTIFY_LOCKED;
				end else begin
					display_code = DISP_UNLOCKED;
					notify_code  = NOTIFY_UNLOCKED;
				end
			end
		endcase
	end

endmodule

[design/keypad_lock_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_lock_controller
// Keypad door-lock controller: one event word in, one result word out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one event word: a tick, a key
//   press, a vibration or a serial command, plus the door-closed level.
//   Output channel (out_valid / out_stall) returns exactly one result word per
//   event, in order: mode, bolt and lamp levels, notify, buzzer and display
//   pulses, PIN buffer fill and link status.
//   Configuration (cfg_valid / cfg_ready) writes one register per handshake;
//   cfg_ready is always high. Write only while no event is in flight.
// Path: an event taken goes to the input register, then to the result register,
//   where its result word is presented and waits until it is taken.
// Throughput: one event per cycle while out_stall is low; the state update
//   between the input register and the result register is combinational.
// Reset: mode starts in the start state; the first event resolves it from
//   the door level. Counters, flags and link status clear, registers load
//   their defaults.
// Stall: a stalled result holds in the result register; one more event waits
//   in the input register, after which in_stall rises until the result moves.
// ----------------------------------------------------------------------------
module keypad_lock_controller
	import kpl_pkg::*;
#(
	parameter int MAX_PIN_KEYS = DEF_MAX_PIN_KEYS,
	parameter int TIMER_BITS   = DEF_TIMER_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	// event channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [3:0]  key_code,
	input  logic [2:0]  command_code,
	input  logic        door_closed,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  mode,
	output logic        bolt_locked,
	output logic        red_led,
	output logic [2:0]  notify_code,
	output logic [2:0]  buzzer_code,
	output logic [3:0]  display_code,
	output logic [3:0]  entry_count,
	output logic [1:0]  wifi_status,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// handshake control
	logic valid_s1;
	logic valid_s2;
	logic s2_free;
	logic advance;
	logic take_in;

	assign s2_free  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign take_in  = in_valid && !in_stall;

	// configuration
	cfg_t cfg;

	assign cfg_ready = 1'b1;

	kpl_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (reg_idx_t'(cfg_index)),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// input register
	op_t        opcode_s1;
	logic [3:0] key_code_s1;
	logic [2:0] command_code_s1;
	logic       door_closed_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			opcode_s1       <= op_t'(opcode);
			key_code_s1     <= key_code;
			command_code_s1 <= command_code;
			door_closed_s1  <= door_closed;
		end
	end

	// lock state
	mode_t                 mode_q;
	logic [TIMER_BITS-1:0] elapsed_q;
	logic                  tamper_q;
	logic [1:0]            link_q;

	mode_t                 mode_nxt;
	logic [TIMER_BITS-1:0] elapsed_nxt;
	logic                  tamper_nxt;
	logic [1:0]            link_nxt;
	buf_ctl_t              buf_ctl;
	buf_hit_t              hit;
	logic [3:0]            count_nxt;
	logic [2:0]            notify_nxt;
	logic [2:0]            buzzer_nxt;
	logic [3:0]            display_nxt;

	kpl_pin_buffer #(
		.MAX_PIN_KEYS (MAX_PIN_KEYS)
	) u_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.ctl         (buf_ctl),
		.cfg         (cfg),
		.hit         (hit),
		.entry_count (count_nxt)
	);

	kpl_step #(
		.TIMER_BITS (TIMER_BITS)
	) u_step (
		.opcode       (opcode_s1),
		.key_code     (key_code_s1),
		.command_code (command_code_s1),
		.door_closed  (door_closed_s1),
		.cfg          (cfg),
		.hit          (hit),
		.mode_q       (mode_q),
		.elapsed_q    (elapsed_q),
		.tamper_q     (tamper_q),
		.link_q       (link_q),
		.mode_nxt     (mode_nxt),
		.elapsed_nxt  (elapsed_nxt),
		.tamper_nxt   (tamper_nxt),
		.link_nxt     (link_nxt),
		.buf_ctl      (buf_ctl),
		.notify_code  (notify_nxt),
		.buzzer_code  (buzzer_nxt),
		.display_code (display_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_START;
			elapsed_q <= '0;
			tamper_q  <= 1'b0;
			link_q    <= LINK_UNKNOWN;
		end else if (advance) begin
			mode_q    <= mode_nxt;
			elapsed_q <= elapsed_nxt;
			tamper_q  <= tamper_nxt;
			link_q    <= link_nxt;
		end
	end

	// result register
	mode_t      mode_s2;
	logic [2:0] notify_s2;
	logic [2:0] buzzer_s2;
	logic [3:0] display_s2;
	logic [1:0] link_s2;
	logic       buf_clear_s2;
	logic       buf_push_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s2      <= mode_nxt;
			notify_s2    <= notify_nxt;
			buzzer_s2    <= buzzer_nxt;
			display_s2   <= display_nxt;
			link_s2      <= link_nxt;
			buf_clear_s2 <= buf_ctl.clear;
			buf_push_s2  <= buf_ctl.push;
		end
	end

	// buffer fill after the step is read straight from the buffer counter,
	// which only moves when the held result moves on
	logic [3:0] count_s2;

	assign count_s2 = count_nxt;

	// output word
	assign out_valid    = valid_s2;
	assign mode         = mode_s2;
	assign bolt_locked  = (mode_s2 != MODE_UNLOCKED);
	assign red_led      = (mode_s2 != MODE_UNLOCKED);
	assign notify_code  = notify_s2;
	assign buzzer_code  = buzzer_s2;
	assign display_code = display_s2;
	assign entry_count  = (buf_clear_s2 && !buf_push_s2) ? 4'd0 : count_s2;
	assign wifi_status  = link_s2;

endmodule

[design/kpl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpl_checker
// Port-level checks of the keypad lock controller, bound to the top level.
// ----------------------------------------------------------------------------
module kpl_checker
	import kpl_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] mode,
	input logic       bolt_locked,
	input logic       red_led,
	input logic [2:0] notify_code,
	input logic [3:0] display_code,
	input logic [3:0] entry_count
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mode) && $stable(notify_code)
			&& $stable(display_code) && $stable(entry_count))
		else $error("stalled result word changed");

	// bolt and lamp follow the mode
	a_bolt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bolt_locked == red_led) && (bolt_locked == (mode != MODE_UNLOCKED)))
		else $error("bolt or lamp level disagrees with mode");

	// keys are only held while a PIN is pending or being reported
	a_keys: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_count != 4'd0 |->
			mode == MODE_AWAIT || mode == MODE_ADMIN || mode == MODE_MESSAGE)
		else $error("PIN buffer not empty outside entry modes");

	// tamper pulse only on entry to alarm
	a_tamper: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && notify_code == NOTIFY_TAMPER |->
			mode == MODE_ALARM && display_code == DISP_TAMPER)
		else $error("tamper notify without alarm");

endmodule

bind keypad_lock_controller kpl_checker u_kpl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.mode         (mode),
	.bolt_locked  (bolt_locked),
	.red_led      (red_led),
	.notify_code  (notify_code),
	.display_code (display_code),
	.entry_count  (entry_count)
);
